// File: sv/mrf_pkg.sv
// Package for the Modbus RTU request framer: frame constants, the data record
// carried along the CRC cell row and the one-byte CRC-16 update.
// No dependencies.
package mrf_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int CRC_SPAN    = 6;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // request bytes in frame order plus the running crc
  typedef struct packed {
    logic [CRC_SPAN-1:0][7:0] bytes;
    logic [15:0]              crc;
  } cell_data_t;

  // fold one byte into a reflected crc-16, one bit per step
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: sv/modbus_rtu_request_framer_core.sv
// Top level of the Modbus RTU request framer: a row of six CRC cells feeding
// the frame serialiser. Depends on mrf_pkg, mrf_crc_cell and mrf_serializer.
//
//  channel  | dir | fields
//  s_*      | in  | tdata[47:0]: slave_address, function_code,
//           |     |   register_address, register_value (lowest bits first)
//  m_*      | out | tdata[7:0]: frame_byte; tlast: last_byte
//
// One request gives eight output bytes, one per cycle while m_tready is high;
// the serialiser takes the next request only when idle or as its last byte goes.
// The first byte passes through the six CRC cells and then the serialiser's
// frame register. Up to six further requests wait in the cell row meanwhile.
// Synchronous reset clears the valid flags and the byte counter only; a stalled
// m_tready freezes the serialiser and the row backs up cell by cell.
module modbus_rtu_request_framer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // slave_address, function_code, register_address, register_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // frame_byte
  output logic        m_tlast    // last_byte
);
  import mrf_pkg::*;

  logic       row_valid [CRC_SPAN+1];
  logic       row_ready [CRC_SPAN+1];
  cell_data_t row_data  [CRC_SPAN+1];

  // request bytes in frame order, register and data words high byte first
  assign row_valid[0]          = s_tvalid;
  assign s_tready              = row_ready[0];
  assign row_data[0].bytes[0]  = s_tdata[7:0];
  assign row_data[0].bytes[1]  = s_tdata[15:8];
  assign row_data[0].bytes[2]  = s_tdata[31:24];
  assign row_data[0].bytes[3]  = s_tdata[23:16];
  assign row_data[0].bytes[4]  = s_tdata[47:40];
  assign row_data[0].bytes[5]  = s_tdata[39:32];
  assign row_data[0].crc       = CRC_INIT;

  // row of crc cells, one frame byte each
  for (genvar g = 0; g < CRC_SPAN; g++) begin : g_cell
    mrf_crc_cell #(.BYTE_SEL(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (row_valid[g]),
      .in_ready  (row_ready[g]),
      .in_data   (row_data[g]),
      .out_valid (row_valid[g+1]),
      .out_ready (row_ready[g+1]),
      .out_data  (row_data[g+1])
    );
  end

  // byte-wide output
  mrf_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (row_valid[CRC_SPAN]),
    .in_ready (row_ready[CRC_SPAN]),
    .in_data  (row_data[CRC_SPAN]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: sv/mrf_crc_cell.sv
// One cell of the CRC row: folds one frame byte into the crc and hands the
// record on to its neighbour. Depends on mrf_pkg.
module mrf_crc_cell #(
  parameter int BYTE_SEL = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrf_pkg::cell_data_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mrf_pkg::cell_data_t out_data
);
  import mrf_pkg::*;

  logic       valid;
  cell_data_t data;

  // accept when empty or when the held record moves on
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // payload with this cell's byte folded in
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data.bytes <= in_data.bytes;
      data.crc   <= crc_byte(in_data.crc, in_data.bytes[BYTE_SEL]);
    end
  end

`ifndef SYNTHESIS
  a_hold_stalled : assert property (@(posedge clk) disable iff (rst)
    valid && !out_ready |=> valid && $stable(data))
    else $error("crc cell lost or changed a stalled record");
  a_take_fill : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> valid)
    else $error("crc cell dropped an accepted record");
  a_empty_after_leave : assert property (@(posedge clk) disable iff (rst)
    valid && out_ready && !in_valid |=> !valid)
    else $error("crc cell repeated a record");
`endif

endmodule

// File: sv/mrf_serializer.sv
// Frame serialiser: takes a finished frame from the CRC row and sends its
// eight bytes one per transaction, the last one flagged. Depends on mrf_pkg.
module mrf_serializer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrf_pkg::cell_data_t in_data,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast
);
  import mrf_pkg::*;

  localparam int COUNT_W = $clog2(FRAME_BYTES);

  logic                        busy;
  logic [COUNT_W-1:0]          count;
  logic [FRAME_BYTES-1:0][7:0] frame;
  logic                        last;
  logic                        load;
  logic                        send;

  assign last     = count == COUNT_W'(FRAME_BYTES - 1);
  assign send     = busy && m_tready;
  assign in_ready = !busy || (m_tready && last);
  assign load     = in_valid && in_ready;

  assign m_tvalid = busy;
  assign m_tdata  = frame[0];
  assign m_tlast  = last;

  // byte counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (load) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (send) begin
      busy  <= !last;
      count <= count + COUNT_W'(1);
    end
  end

  // frame shift register, byte in transmit order at the bottom
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < CRC_SPAN; i++) begin
        frame[i] <= in_data.bytes[i];
      end
      frame[CRC_SPAN]   <= in_data.crc[7:0];
      frame[CRC_SPAN+1] <= in_data.crc[15:8];
    end else if (send) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
        frame[i] <= frame[i+1];
      end
      frame[FRAME_BYTES-1] <= 8'h00;
    end
  end

`ifndef SYNTHESIS
  a_load_restart : assert property (@(posedge clk) disable iff (rst)
    load |=> busy && count == '0)
    else $error("serialiser did not restart on a new frame");
  a_idle_count : assert property (@(posedge clk) disable iff (rst)
    !busy |-> count == '0)
    else $error("serialiser count left over while idle");
  a_last_ends : assert property (@(posedge clk) disable iff (rst)
    send && last && !in_valid |=> !busy)
    else $error("serialiser sent past the end of the frame");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for modbus_rtu_request_framer_core: random and directed requests,
// each eight-byte frame checked byte by byte against a CRC-16 frame predictor.
// Depends on mrf_pkg and the framer core RTL.
`timescale 1ns / 100ps

module tb_top;
  import mrf_pkg::FRAME_BYTES;
  import mrf_pkg::CRC_SPAN;
  import mrf_pkg::CRC_INIT;
  import mrf_pkg::CRC_POLY;

  // request fields, slave_address in the lowest bits as on s_tdata
  typedef struct packed {
    logic [15:0] register_value;
    logic [15:0] register_address;
    logic [7:0]  function_code;
    logic [7:0]  slave_address;
  } modbus_request_t;

  // one expected frame byte
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_byte_t;

  localparam int REQUEST_COUNT = 410;
  localparam int DRAIN_CYCLES  = 20;

  // frame predictor and store of expected frame bytes
  class modbus_frame_scoreboard;
    frame_byte_t expected_bytes[$];
    int unsigned requests_seen;
    int unsigned bytes_checked;
    int unsigned error_count;

    // reflected crc-16, fed one data bit at a time
    function automatic logic [15:0] modbus_crc16(input logic [7:0] span[CRC_SPAN]);
      logic [15:0] crc;
      logic        feedback;
      crc = CRC_INIT;
      for (int k = 0; k < CRC_SPAN; k++) begin
        for (int i = 0; i < 8; i++) begin
          feedback = crc[0] ^ span[k][i];
          crc = crc >> 1;
          if (feedback) begin
            crc = crc ^ CRC_POLY;
          end
        end
      end
      return crc;
    endfunction

    // accepted request: queue its eight frame bytes in transmit order
    function void note_request(input modbus_request_t req);
      logic [7:0]  frame[FRAME_BYTES];
      logic [7:0]  span[CRC_SPAN];
      logic [15:0] crc;
      frame_byte_t fb;
      frame[0] = req.slave_address;
      frame[1] = req.function_code;
      frame[2] = req.register_address[15:8];
      frame[3] = req.register_address[7:0];
      frame[4] = req.register_value[15:8];
      frame[5] = req.register_value[7:0];
      for (int k = 0; k < CRC_SPAN; k++) begin
        span[k] = frame[k];
      end
      crc = modbus_crc16(span);
      // crc goes out low byte first
      frame[6] = crc[7:0];
      frame[7] = crc[15:8];
      for (int k = 0; k < FRAME_BYTES; k++) begin
        fb.frame_byte = frame[k];
        fb.last_byte  = (k == FRAME_BYTES - 1);
        expected_bytes.push_back(fb);
      end
      requests_seen++;
    endfunction

    // accepted output byte: compare with the oldest expectation
    function void check_byte(input logic [7:0] frame_byte, input logic last_byte);
      frame_byte_t fb;
      if (expected_bytes.size() == 0) begin
        $error("frame_byte %02h (last_byte %0b) arrived with nothing expected",
               frame_byte, last_byte);
        error_count++;
        return;
      end
      fb = expected_bytes.pop_front();
      bytes_checked++;
      if (frame_byte !== fb.frame_byte) begin
        $error("frame_byte: expected %02h, got %02h", fb.frame_byte, frame_byte);
        error_count++;
      end
      if (last_byte !== fb.last_byte) begin
        $error("last_byte: expected %0b, got %0b", fb.last_byte, last_byte);
        error_count++;
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // slave_address, function_code, register_address, register_value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // frame_byte
  logic        m_tlast;        // last_byte

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  modbus_frame_scoreboard frames = new();

  modbus_rtu_request_framer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // watch both channels for completed transactions
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        frames.note_request(modbus_request_t'(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        frames.check_byte(m_tdata, m_tlast);
      end
    end
  end

  function automatic modbus_request_t make_request(input logic [7:0] addr,
                                                    input logic [7:0] func,
                                                    input logic [15:0] reg_num,
                                                    input logic [15:0] data);
    modbus_request_t req;
    req.slave_address    = addr;
    req.function_code    = func;
    req.register_address = reg_num;
    req.register_value   = data;
    return req;
  endfunction

  // present one request and hold it until the transaction completes
  task automatic send_request(input modbus_request_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop sending until every queued frame byte has come out
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (frames.outstanding() != 0) @(posedge clk);
  endtask

  // mostly plausible requests, some fully random noise
  function automatic modbus_request_t random_request();
    if ($urandom_range(99) < 70) begin
      return make_request(8'($urandom_range(1, 247)), 8'($urandom_range(1, 24)),
                          16'($urandom_range(0, 1023)), 16'($urandom()));
    end
    return make_request(8'($urandom()), 8'($urandom()), 16'($urandom()), 16'($urandom()));
  endfunction

  // overall time limit
  initial begin
    #5_000_000;
    $display("modbus_rtu_request_framer_core: mismatch");
    $finish;
  end

  initial begin
    int directed_count;
    int per_phase;
    directed_count = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, bit patterns, typical requests
    begin
      modbus_request_t directed[$];
      directed.push_back(make_request(8'h00, 8'h00, 16'h0000, 16'h0000));
      directed.push_back(make_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
      directed.push_back(make_request(8'hAA, 8'h55, 16'hAA55, 16'h55AA));
      directed.push_back(make_request(8'h55, 8'hAA, 16'h55AA, 16'hAA55));
      directed.push_back(make_request(8'h01, 8'h03, 16'h0000, 16'h000A));
      directed.push_back(make_request(8'h01, 8'h06, 16'h0001, 16'h0003));
      directed.push_back(make_request(8'h11, 8'h10, 16'h0001, 16'h0002));
      directed.push_back(make_request(8'h00, 8'h06, 16'h0100, 16'h1234));
      directed.push_back(make_request(8'hF7, 8'h04, 16'h8000, 16'h0001));
      directed.push_back(make_request(8'h80, 8'h01, 16'h0001, 16'h8000));
      directed.push_back(make_request(8'h01, 8'h80, 16'h7FFF, 16'hFFFE));
      directed.push_back(make_request(8'hFE, 8'h7F, 16'hFF00, 16'h00FF));
      directed.push_back(make_request(8'h00, 8'h00, 16'h0000, 16'h0001));
      directed.push_back(make_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFE));
      directed.push_back(make_request(8'h0F, 8'hF0, 16'h0F0F, 16'hF0F0));
      directed.push_back(make_request(8'h3C, 8'hC3, 16'hC33C, 16'h3CC3));
      foreach (directed[i]) begin
        send_request(directed[i]);
        directed_count++;
      end
    end
    wait_for_drain();

    // random part across four pacing phases
    per_phase = (REQUEST_COUNT - directed_count) / 4;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 47;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 47;
        end
        default: begin
          sender_idle_pct    = 6;
          receiver_stall_pct = 6;
        end
      endcase
      for (int n = 0; n < per_phase; n++) begin
        send_request(random_request());
        // a single mid-phase pause in phase 2 so the pipe empties completely
        if (n == per_phase / 2 && phase == 2) begin
          wait_for_drain();
        end
      end
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    if (frames.outstanding() != 0) begin
      $error("%0d frame bytes never arrived", frames.outstanding());
      frames.error_count++;
    end

    $display("run covered %0d requests and %0d frame bytes", frames.requests_seen,
             frames.bytes_checked);
    $display("pacing: free flow, sender gaps, receiver stalls and light mixed idling");
    if (frames.error_count == 0) begin
      $display("modbus_rtu_request_framer_core: match");
    end else begin
      $display("modbus_rtu_request_framer_core: mismatch");
    end
    $finish;
  end

endmodule

// File: modbus_rtu_request_framer_core.f
sv/mrf_pkg.sv
sv/mrf_crc_cell.sv
sv/mrf_serializer.sv
sv/modbus_rtu_request_framer_core.sv
tb/tb_top.sv
